[sv/mmdp_pkg.sv]
package mmdp_pkg;

   // fixed field widths
   localparam int CFG_W     = 5;
   localparam int IDX_IN_W  = 4;
   localparam int VAL_W     = 16;
   localparam int MUL_W     = 2 * VAL_W;
   localparam int PROD_W    = 40;
   localparam int CSR_IDX_W = 2;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   // register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROWS_A    = 2'd0,
      REG_INNER_DIM = 2'd1,
      REG_COLS_B    = 2'd2,
      REG_UNUSED    = 2'd3
   } reg_idx_type;

   // request kinds carried in req_tuser
   typedef enum logic [1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic wr_a;
      logic wr_b;
      logic start;
      logic issue;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic wr_a_ok;
      logic wr_b_ok;
      logic cmp_ok;
      logic last_k;
      logic pipe_busy;
      logic rsp_free;
   } status_type;

endpackage

[sv/mmdp_ctrl.sv]
module mmdp_ctrl
   import mmdp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  op_type     req_op,
   input  status_type stat,
   output logic       req_ready,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_op)
                  OP_WRITE_A: cmd.wr_a = stat.wr_a_ok;
                  OP_WRITE_B: cmd.wr_b = stat.wr_b_ok;
                  OP_COMPUTE: begin
                     cmd.start = 1'b1;
                     state_in  = stat.cmp_ok ? ST_RUN : ST_RESULT;
                  end
                  OP_NONE: ;
               endcase
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (stat.last_k) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

endmodule

[sv/mmdp_datapath.sv]
module mmdp_datapath
   import mmdp_pkg::*;
#(
   parameter int MAX_DIM = 16
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic [IDX_IN_W-1:0]  req_row,
   input  logic [IDX_IN_W-1:0]  req_column,
   input  logic [VAL_W-1:0]     req_value,
   input  cmd_type              cmd,
   output status_type           stat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PROD_W-1:0]    rsp_product,
   output logic                 rsp_range_error
);

   localparam int IW    = $clog2(MAX_DIM);
   localparam int CNT_W = $clog2(MAX_DIM + 1);

   logic [CFG_W-1:0] rows_a_ff;
   logic [CFG_W-1:0] inner_dim_ff;
   logic [CFG_W-1:0] cols_b_ff;

   logic [CNT_W-1:0] ra_eff;
   logic [CNT_W-1:0] kd_eff;
   logic [CNT_W-1:0] cb_eff;

   logic [VAL_W-1:0] mem_a [MAX_DIM][MAX_DIM];
   logic [VAL_W-1:0] mem_b [MAX_DIM][MAX_DIM];

   logic [IW-1:0]    row_ff;
   logic [IW-1:0]    col_ff;
   logic [CNT_W-1:0] k_ff;
   logic [IW-1:0]    k_idx;
   logic             err_ff;

   logic signed [VAL_W-1:0]  a_rd_ff;
   logic signed [VAL_W-1:0]  b_rd_ff;
   logic                     rd_vld_ff;
   logic signed [MUL_W-1:0]  mul_ff;
   logic                     mul_vld_ff;
   logic [PROD_W-1:0]        acc_ff;
   logic [PROD_W-1:0]        acc_in;

   logic [PROD_W-1:0] product_ff;
   logic              range_error_ff;
   logic              rsp_valid_ff;

   function automatic logic [CNT_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > MAX_DIM) begin
         r = CNT_W'(MAX_DIM);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= CFG_RESET;
         inner_dim_ff <= CFG_RESET;
         cols_b_ff    <= CFG_RESET;
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_index))
            REG_ROWS_A:    rows_a_ff    <= csr_wdata;
            REG_INNER_DIM: inner_dim_ff <= csr_wdata;
            REG_COLS_B:    cols_b_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign ra_eff = clamp_size(rows_a_ff);
   assign kd_eff = clamp_size(inner_dim_ff);
   assign cb_eff = clamp_size(cols_b_ff);

   assign stat.wr_a_ok = (req_row < ra_eff) && (req_column < kd_eff);
   assign stat.wr_b_ok = (req_row < kd_eff) && (req_column < cb_eff);
   assign stat.cmp_ok  = (req_row < ra_eff) && (req_column < cb_eff);
   assign stat.last_k  = (k_ff == (kd_eff - CNT_W'(1)));
   assign stat.pipe_busy = rd_vld_ff | mul_vld_ff;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign k_idx = k_ff[IW-1:0];

   // matrix stores
   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         mem_a[IW'(req_row)][IW'(req_column)] <= req_value;
      end
      if (cmd.wr_b) begin
         mem_b[IW'(req_row)][IW'(req_column)] <= req_value;
      end
      if (cmd.issue) begin
         a_rd_ff <= mem_a[row_ff][k_idx];
         b_rd_ff <= mem_b[k_idx][col_ff];
      end
   end

   // compute item context and inner index
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         row_ff <= IW'(req_row);
         col_ff <= IW'(req_column);
         err_ff <= !stat.cmp_ok;
         k_ff   <= '0;
      end else if (cmd.issue) begin
         k_ff <= k_ff + CNT_W'(1);
      end
   end

   // multiply, then accumulate
   always_ff @(posedge clock) begin
      mul_ff <= a_rd_ff * b_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= cmd.issue;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.start) begin
         acc_in = '0;
      end else if (mul_vld_ff) begin
         acc_in = acc_ff + {{(PROD_W - MUL_W){mul_ff[MUL_W-1]}}, mul_ff};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         product_ff     <= err_ff ? '0 : acc_ff;
         range_error_ff <= err_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_product     = product_ff;
   assign rsp_range_error = range_error_ff;

endmodule

[sv/matrix_multiply_dot_product.sv]
// Dense matrix multiply, one C entry per compute beat. Request beats write one
// Q8.8 entry of A or B (kind in req_tuser) or ask for C[row][column], the exact
// dot product of row "row" of A with column "column" of B over inner_dim terms,
// returned in signed Q24.16 on rsp_tdata. Writes outside the configured sizes
// are dropped; a compute outside rows_a x cols_b returns zero with the range
// flag set in rsp_tuser. Write beats do not hold off the next request. A
// compute beat runs from acceptance to the result register as one shared
// multiply-accumulate issue per inner term from a registered read of both
// stores, a drain while the read, multiply and accumulate stages empty, then
// the load of the result once the result register is free; an out-of-range
// compute skips the issue and drain and goes straight to that load. Requests
// are taken only while no compute is in flight; a finished result waits in its
// own register and does not block the next request, but a compute that
// finishes while that register is still held waits for it and holds off
// requests meanwhile. Size registers read as 1 when written 0 and saturate at
// MAX_DIM. Entries must be written before a compute reads them.
module matrix_multiply_dot_product
   import mmdp_pkg::*;
#(
   parameter int MAX_DIM = 16
)
(
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,  // row[3:0], column[7:4], value[23:8]
   input  logic [1:0]           req_tuser,  // operation[1:0]
   // result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [PROD_W-1:0]    rsp_tdata,  // product[39:0]
   output logic                 rsp_tuser   // range_error[0]
);

   cmd_type    cmd;
   status_type stat;

   // request field split
   logic [IDX_IN_W-1:0] req_row;
   logic [IDX_IN_W-1:0] req_column;
   logic [VAL_W-1:0]    req_value;
   op_type              req_op;

   assign req_row    = req_tdata[3:0];
   assign req_column = req_tdata[7:4];
   assign req_value  = req_tdata[23:8];
   assign req_op     = op_type'(req_tuser);

   mmdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_op),
      .stat      (stat),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   mmdp_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_row         (req_row),
      .req_column      (req_column),
      .req_value       (req_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_product     (rsp_tdata),
      .rsp_range_error (rsp_tuser)
   );

endmodule
